// ===== rtl/core/qts_pkg.sv =====
// ----------------------------------------------------------------------------
// qts_pkg
// Shared widths, codes and inter-stage types of the quintic trajectory sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

	localparam int TAU_FRAC_BITS = 24;
	localparam int TAU_W         = TAU_FRAC_BITS + 1;
	localparam int INNER_W       = TAU_W + 4;
	localparam int S1_W          = TAU_W;
	localparam int S2_W          = TAU_W + 2;
	localparam int DATA_W        = 32;
	localparam int SQ_W          = 2 * DATA_W;
	localparam int NUM_W         = 67;
	localparam int VEL_W         = 48;
	localparam int ACC_W         = 64;
	localparam int VEL_SHIFT     = 16;
	localparam int ACC_SHIFT     = 32;

	localparam logic [TAU_W-1:0]   TAU_ONE = {1'b1, {TAU_FRAC_BITS{1'b0}}};
	localparam logic [INNER_W-1:0] TEN_ONE = {4'b0, TAU_ONE} * 4'd10;

	typedef enum logic [1:0] {
		WIN_INSIDE = 2'd0,
		WIN_BEFORE = 2'd1,
		WIN_AFTER  = 2'd2
	} win_status_t;

	typedef enum logic [1:0] {
		REG_START_POS  = 2'd0,
		REG_GOAL_POS   = 2'd1,
		REG_START_TIME = 2'd2,
		REG_DURATION   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [DATA_W-1:0] dur;
		logic [SQ_W-1:0]   dur_sq;
		logic [DATA_W-1:0] dmag;
		logic              dneg;
		logic [DATA_W-1:0] start_pos;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic              full;
		win_status_t       status;
	} tau_req_t;

	typedef struct packed {
		logic [TAU_W-1:0] tau;
		win_status_t      status;
	} tau_item_t;

	typedef struct packed {
		logic [NUM_W-1:0]  v_num;
		logic [NUM_W-1:0]  a_num;
		logic              v_neg;
		logic              a_neg;
		logic [DATA_W-1:0] position;
		win_status_t       status;
	} scale_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] position;
		logic [VEL_W-1:0]  velocity;
		logic [ACC_W-1:0]  acceleration;
		win_status_t       status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/qts_tau_div.sv =====
// ----------------------------------------------------------------------------
// qts_tau_div
// Pipelined restoring divider: one quotient bit of tau per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_tau_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            go,
	input  wire logic                            in_vld,
	input  wire qts_pkg::tau_req_t               req,
	input  wire logic [qts_pkg::DATA_W-1:0]      dur,
	output logic                                 out_vld,
	output qts_pkg::tau_item_t                   item
);

	typedef struct packed {
		logic [qts_pkg::DATA_W-1:0]        rem;
		logic [qts_pkg::TAU_FRAC_BITS-1:0] quo;
		logic                              full;
		qts_pkg::win_status_t              status;
	} tau_stage_t;

	tau_stage_t                         stg_s [0:qts_pkg::TAU_FRAC_BITS];
	tau_stage_t                         nxt   [0:qts_pkg::TAU_FRAC_BITS-1];
	logic [qts_pkg::TAU_FRAC_BITS:0]    vld_s;

	for (genvar k = 0; k < qts_pkg::TAU_FRAC_BITS; k++) begin : g_step
		logic [qts_pkg::DATA_W:0] trial;
		logic [qts_pkg::DATA_W:0] diff;
		logic                     ge;
		always_comb begin
			trial = {stg_s[k].rem, 1'b0};
			diff  = trial - {1'b0, dur};
			ge    = trial >= {1'b0, dur};
			nxt[k]        = stg_s[k];
			nxt[k].rem    = ge ? diff[qts_pkg::DATA_W-1:0] : trial[qts_pkg::DATA_W-1:0];
			nxt[k].quo    = {stg_s[k].quo[qts_pkg::TAU_FRAC_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (go) begin
			vld_s <= {vld_s[qts_pkg::TAU_FRAC_BITS-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			stg_s[0].rem    <= req.rem;
			stg_s[0].quo    <= '0;
			stg_s[0].full   <= req.full;
			stg_s[0].status <= req.status;
			for (int k = 0; k < qts_pkg::TAU_FRAC_BITS; k++) begin
				stg_s[k+1] <= nxt[k];
			end
		end
	end

	// exact end and after end force tau to one
	assign out_vld     = vld_s[qts_pkg::TAU_FRAC_BITS];
	assign item.tau    = stg_s[qts_pkg::TAU_FRAC_BITS].full ? qts_pkg::TAU_ONE
		: {1'b0, stg_s[qts_pkg::TAU_FRAC_BITS].quo};
	assign item.status = stg_s[qts_pkg::TAU_FRAC_BITS].status;

	a_before_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && stg_s[qts_pkg::TAU_FRAC_BITS].status == qts_pkg::WIN_BEFORE
		|-> stg_s[qts_pkg::TAU_FRAC_BITS].quo == '0 && !stg_s[qts_pkg::TAU_FRAC_BITS].full)
		else $error("tau not zero before move start");

	a_after_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && stg_s[qts_pkg::TAU_FRAC_BITS].status == qts_pkg::WIN_AFTER
		|-> stg_s[qts_pkg::TAU_FRAC_BITS].full)
		else $error("tau not one after move end");

endmodule

`default_nettype wire

// ===== rtl/core/qts_poly.sv =====
// ----------------------------------------------------------------------------
// qts_poly
// Quintic profile and its derivatives, scaled by the move distance.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_poly (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic                 in_vld,
	input  wire qts_pkg::tau_item_t   item,
	input  wire qts_pkg::cfg_t        cfg,
	output logic                      out_vld,
	output qts_pkg::scale_req_t       req
);

	typedef struct packed {
		logic [qts_pkg::TAU_W-1:0] tau;
		logic [qts_pkg::TAU_W-1:0] tau2;
		logic [qts_pkg::TAU_W-1:0] uu;
		logic [qts_pkg::TAU_W-1:0] tu;
		logic [qts_pkg::TAU_W-1:0] w;
		logic                      wneg;
		qts_pkg::win_status_t      status;
	} pa_t;

	typedef struct packed {
		logic [qts_pkg::TAU_W-1:0]   tau3;
		logic [qts_pkg::INNER_W-1:0] inner;
		logic [qts_pkg::TAU_W-1:0]   s1pre;
		logic [qts_pkg::TAU_W-1:0]   s2pre;
		logic                        wneg;
		qts_pkg::win_status_t        status;
	} pb_t;

	typedef struct packed {
		logic [qts_pkg::TAU_W-1:0] s;
		logic [qts_pkg::S1_W-1:0]  s1;
		logic [qts_pkg::S2_W-1:0]  s2;
		logic                      wneg;
		qts_pkg::win_status_t      status;
	} pc_t;

	typedef struct packed {
		logic [qts_pkg::DATA_W-1:0] pmag;
		logic [qts_pkg::NUM_W-1:0]  v_num;
		logic [qts_pkg::NUM_W-1:0]  a_num;
		logic                       wneg;
		qts_pkg::win_status_t       status;
	} pd_t;

	localparam int F = qts_pkg::TAU_FRAC_BITS;

	qts_pkg::tau_item_t st_s1;
	pa_t                st_s2;
	pb_t                st_s3;
	pc_t                st_s4;
	pd_t                st_s5;
	logic [5:1]         vld_s;

	pa_t pa_n;
	pb_t pb_n;
	pc_t pc_n;
	pd_t pd_n;

	// stage 1 -> 2: squares and cross terms
	logic [qts_pkg::TAU_W-1:0]   u;
	logic [qts_pkg::TAU_W:0]     two_tau;
	logic [2*qts_pkg::TAU_W-1:0] p_tt, p_uu, p_tu;
	always_comb begin
		u       = qts_pkg::TAU_ONE - st_s1.tau;
		two_tau = {st_s1.tau, 1'b0};
		p_tt    = st_s1.tau * st_s1.tau;
		p_uu    = u * u;
		p_tu    = st_s1.tau * u;
		pa_n.tau    = st_s1.tau;
		pa_n.tau2   = p_tt[F +: qts_pkg::TAU_W];
		pa_n.uu     = p_uu[F +: qts_pkg::TAU_W];
		pa_n.tu     = p_tu[F +: qts_pkg::TAU_W];
		pa_n.wneg   = two_tau > {1'b0, qts_pkg::TAU_ONE};
		pa_n.w      = pa_n.wneg ? two_tau[qts_pkg::TAU_W-1:0] - qts_pkg::TAU_ONE
			: qts_pkg::TAU_ONE - two_tau[qts_pkg::TAU_W-1:0];
		pa_n.status = st_s1.status;
	end

	// stage 2 -> 3: cube, inner polynomial, derivative products
	logic [2*qts_pkg::TAU_W-1:0] p_t3, p_s1, p_s2;
	always_comb begin
		p_t3 = st_s2.tau2 * st_s2.tau;
		p_s1 = st_s2.tau2 * st_s2.uu;
		p_s2 = st_s2.tu * st_s2.w;
		pb_n.tau3  = p_t3[F +: qts_pkg::TAU_W];
		pb_n.s1pre = p_s1[F +: qts_pkg::TAU_W];
		pb_n.s2pre = p_s2[F +: qts_pkg::TAU_W];
		// 10*one - 15*tau + 6*tau2, always at least one
		pb_n.inner = qts_pkg::TEN_ONE + {2'b0, st_s2.tau2, 2'b0} + {3'b0, st_s2.tau2, 1'b0}
			- {st_s2.tau, 4'b0} + {4'b0, st_s2.tau};
		pb_n.wneg   = st_s2.wneg;
		pb_n.status = st_s2.status;
	end

	// stage 3 -> 4: profile value and constant scaling
	logic [qts_pkg::TAU_W+qts_pkg::INNER_W-1:0] p_s;
	logic [qts_pkg::TAU_W+4:0]                  s1_full;
	logic [qts_pkg::TAU_W+5:0]                  s2_full;
	always_comb begin
		p_s     = st_s3.tau3 * st_s3.inner;
		s1_full = {st_s3.s1pre, 5'b0} - {4'b0, st_s3.s1pre, 1'b0};
		s2_full = {st_s3.s2pre, 6'b0} - {4'b0, st_s3.s2pre, 2'b0};
		pc_n.s      = p_s[F +: qts_pkg::TAU_W];
		pc_n.s1     = s1_full[qts_pkg::S1_W-1:0];
		pc_n.s2     = s2_full[qts_pkg::S2_W-1:0];
		pc_n.wneg   = st_s3.wneg;
		pc_n.status = st_s3.status;
	end

	// stage 4 -> 5: scale by distance
	localparam int VW = qts_pkg::NUM_W + qts_pkg::DATA_W + qts_pkg::S1_W + qts_pkg::VEL_SHIFT;
	localparam int AW = qts_pkg::NUM_W + qts_pkg::DATA_W + qts_pkg::S2_W + qts_pkg::ACC_SHIFT;
	logic [qts_pkg::DATA_W+qts_pkg::TAU_W-1:0] p_pos;
	logic [qts_pkg::DATA_W+qts_pkg::S1_W-1:0]  p_vel;
	logic [qts_pkg::DATA_W+qts_pkg::S2_W-1:0]  p_acc;
	logic [VW-1:0]                             v_wide;
	logic [AW-1:0]                             a_wide;
	always_comb begin
		p_pos  = cfg.dmag * st_s4.s;
		p_vel  = cfg.dmag * st_s4.s1;
		p_acc  = cfg.dmag * st_s4.s2;
		v_wide = {{qts_pkg::NUM_W{1'b0}}, p_vel, {qts_pkg::VEL_SHIFT{1'b0}}} >> F;
		a_wide = {{qts_pkg::NUM_W{1'b0}}, p_acc, {qts_pkg::ACC_SHIFT{1'b0}}} >> F;
		pd_n.pmag   = p_pos[F +: qts_pkg::DATA_W];
		pd_n.v_num  = v_wide[qts_pkg::NUM_W-1:0];
		pd_n.a_num  = a_wide[qts_pkg::NUM_W-1:0];
		pd_n.wneg   = st_s4.wneg;
		pd_n.status = st_s4.status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (go) begin
			vld_s <= {vld_s[4:1], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			st_s1 <= item;
			st_s2 <= pa_n;
			st_s3 <= pb_n;
			st_s4 <= pc_n;
			st_s5 <= pd_n;
		end
	end

	assign out_vld      = vld_s[5];
	assign req.v_num    = st_s5.v_num;
	assign req.a_num    = st_s5.a_num;
	assign req.v_neg    = cfg.dneg;
	assign req.a_neg    = cfg.dneg ^ st_s5.wneg;
	assign req.position = cfg.start_pos + (cfg.dneg ? (~st_s5.pmag + 1'b1) : st_s5.pmag);
	assign req.status   = st_s5.status;

	a_inner_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] |-> st_s3.inner >= {4'b0, qts_pkg::TAU_ONE})
		else $error("inner polynomial below one");

endmodule

`default_nettype wire

// ===== rtl/core/qts_scale_div.sv =====
// ----------------------------------------------------------------------------
// qts_scale_div
// Twin pipelined dividers: velocity by duration, acceleration by duration
// squared, then saturation to the output widths.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_scale_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic                 in_vld,
	input  wire qts_pkg::scale_req_t  req,
	input  wire qts_pkg::cfg_t        cfg,
	output logic                      out_vld,
	output qts_pkg::result_t          res
);

	localparam int N = qts_pkg::NUM_W;

	typedef struct packed {
		logic [qts_pkg::DATA_W-1:0] vr;
		logic [N-1:0]               vnq;
		logic [qts_pkg::SQ_W-1:0]   ar;
		logic [N-1:0]               anq;
		logic                       v_neg;
		logic                       a_neg;
		logic [qts_pkg::DATA_W-1:0] position;
		qts_pkg::win_status_t       status;
	} sd_stage_t;

	sd_stage_t stg_s [0:N];
	sd_stage_t nxt   [0:N-1];
	logic [N:0] vld_s;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [qts_pkg::DATA_W:0] vt, vd;
		logic [qts_pkg::SQ_W:0]   at, ad;
		logic                     vge, age;
		always_comb begin
			vt  = {stg_s[k].vr, stg_s[k].vnq[N-1]};
			vd  = vt - {1'b0, cfg.dur};
			vge = vt >= {1'b0, cfg.dur};
			at  = {stg_s[k].ar, stg_s[k].anq[N-1]};
			ad  = at - {1'b0, cfg.dur_sq};
			age = at >= {1'b0, cfg.dur_sq};
			nxt[k]     = stg_s[k];
			nxt[k].vr  = vge ? vd[qts_pkg::DATA_W-1:0] : vt[qts_pkg::DATA_W-1:0];
			nxt[k].vnq = {stg_s[k].vnq[N-2:0], vge};
			nxt[k].ar  = age ? ad[qts_pkg::SQ_W-1:0] : at[qts_pkg::SQ_W-1:0];
			nxt[k].anq = {stg_s[k].anq[N-2:0], age};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (go) begin
			vld_s <= {vld_s[N-1:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			stg_s[0].vr       <= '0;
			stg_s[0].vnq      <= req.v_num;
			stg_s[0].ar       <= '0;
			stg_s[0].anq      <= req.a_num;
			stg_s[0].v_neg    <= req.v_neg;
			stg_s[0].a_neg    <= req.a_neg;
			stg_s[0].position <= req.position;
			stg_s[0].status   <= req.status;
			for (int k = 0; k < N; k++) begin
				stg_s[k+1] <= nxt[k];
			end
		end
	end

	// saturate magnitudes, then apply sign
	logic [qts_pkg::VEL_W-1:0] vlim, vmag;
	logic [qts_pkg::ACC_W-1:0] alim, amag;
	always_comb begin
		vlim = {1'b0, {(qts_pkg::VEL_W-1){1'b1}}} + {{(qts_pkg::VEL_W-1){1'b0}}, stg_s[N].v_neg};
		alim = {1'b0, {(qts_pkg::ACC_W-1){1'b1}}} + {{(qts_pkg::ACC_W-1){1'b0}}, stg_s[N].a_neg};
		vmag = (stg_s[N].vnq > {{(N-qts_pkg::VEL_W){1'b0}}, vlim}) ? vlim
			: stg_s[N].vnq[qts_pkg::VEL_W-1:0];
		amag = (stg_s[N].anq > {{(N-qts_pkg::ACC_W){1'b0}}, alim}) ? alim
			: stg_s[N].anq[qts_pkg::ACC_W-1:0];
		res.position     = stg_s[N].position;
		res.velocity     = stg_s[N].v_neg ? (~vmag + 1'b1) : vmag;
		res.acceleration = stg_s[N].a_neg ? (~amag + 1'b1) : amag;
		res.status       = stg_s[N].status;
	end

	assign out_vld = vld_s[N];

endmodule

`default_nettype wire

// ===== rtl/core/quintic_trajectory_sampler.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_sampler
// Samples a rest-to-rest quintic move at given time stamps: position,
// velocity per tick and acceleration per tick squared.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid / in_ready        | sample_time
//   output   | out_valid / out_ready      | position, velocity, acceleration,
//            |                            | window_status
//   config   | cfg_wr_en                  | cfg_index, cfg_wdata
//
// One time stamp per cycle while the skid stage is empty; the pipeline depth is
// set by the tau divider (one bit per stage) and the 67-step scale dividers.
// Reset clears valid bits and loads the register reset values.
// A full skid stage behind the output register freezes the whole pipeline;
// until then new time stamps are taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_trajectory_sampler (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [qts_pkg::DATA_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [qts_pkg::DATA_W-1:0]   sample_time,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [qts_pkg::DATA_W-1:0] position,
	output logic signed [qts_pkg::VEL_W-1:0]  velocity,
	output logic signed [qts_pkg::ACC_W-1:0]  acceleration,
	output logic [1:0]                        window_status
);

	logic [qts_pkg::DATA_W-1:0] start_pos_q, goal_pos_q, start_time_q, duration_q;
	logic [qts_pkg::DATA_W-1:0] dur_eff;
	logic [qts_pkg::SQ_W-1:0]   dur_sq_q;
	logic [qts_pkg::DATA_W-1:0] dmag_q;
	logic                       dneg_q;
	logic [qts_pkg::DATA_W:0]   span;
	qts_pkg::cfg_t              cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_pos_q  <= '0;
			goal_pos_q   <= '0;
			start_time_q <= '0;
			duration_q   <= {{(qts_pkg::DATA_W-1){1'b0}}, 1'b1};
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				qts_pkg::REG_START_POS:  start_pos_q  <= cfg_wdata;
				qts_pkg::REG_GOAL_POS:   goal_pos_q   <= cfg_wdata;
				qts_pkg::REG_START_TIME: start_time_q <= cfg_wdata;
				qts_pkg::REG_DURATION:   duration_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// zero duration acts as one
	assign dur_eff = (duration_q == '0) ? {{(qts_pkg::DATA_W-1){1'b0}}, 1'b1} : duration_q;
	assign span    = {goal_pos_q[qts_pkg::DATA_W-1], goal_pos_q}
		- {start_pos_q[qts_pkg::DATA_W-1], start_pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_sq_q <= {{(qts_pkg::SQ_W-1){1'b0}}, 1'b1};
			dmag_q   <= '0;
			dneg_q   <= 1'b0;
		end else begin
			dur_sq_q <= dur_eff * dur_eff;
			dneg_q   <= span[qts_pkg::DATA_W];
			dmag_q   <= span[qts_pkg::DATA_W] ? (~span[qts_pkg::DATA_W-1:0] + 1'b1)
				: span[qts_pkg::DATA_W-1:0];
		end
	end

	assign cfg.dur       = dur_eff;
	assign cfg.dur_sq    = dur_sq_q;
	assign cfg.dmag      = dmag_q;
	assign cfg.dneg      = dneg_q;
	assign cfg.start_pos = start_pos_q;

	// pipeline advance and input stage
	logic                       go;
	logic                       vld_s1;
	logic [qts_pkg::DATA_W-1:0] t_s1;
	logic                       skid_vld_q, out_vld_q;
	qts_pkg::result_t           skid_q, out_q;

	assign go       = !skid_vld_q;
	assign in_ready = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (go) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			t_s1 <= sample_time;
		end
	end

	// window check and divider setup
	logic [qts_pkg::DATA_W-1:0] elapsed;
	logic                       is_before, is_after, is_end;
	qts_pkg::tau_req_t          tau_req;
	always_comb begin
		elapsed   = t_s1 - start_time_q;
		is_before = t_s1 < start_time_q;
		is_after  = !is_before && (elapsed > dur_eff);
		is_end    = !is_before && (elapsed == dur_eff);
		tau_req.full = is_after || is_end;
		tau_req.rem  = (is_before || is_after || is_end) ? '0 : elapsed;
		priority if (is_before) begin
			tau_req.status = qts_pkg::WIN_BEFORE;
		end else if (is_after) begin
			tau_req.status = qts_pkg::WIN_AFTER;
		end else begin
			tau_req.status = qts_pkg::WIN_INSIDE;
		end
	end

	logic                 tau_vld, poly_vld, res_vld;
	qts_pkg::tau_item_t   tau_item;
	qts_pkg::scale_req_t  scale_req;
	qts_pkg::result_t     res;

	qts_tau_div u_tau_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.in_vld  (vld_s1),
		.req     (tau_req),
		.dur     (dur_eff),
		.out_vld (tau_vld),
		.item    (tau_item)
	);

	qts_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.in_vld  (tau_vld),
		.item    (tau_item),
		.cfg     (cfg),
		.out_vld (poly_vld),
		.req     (scale_req)
	);

	qts_scale_div u_scale_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.in_vld  (poly_vld),
		.req     (scale_req),
		.cfg     (cfg),
		.out_vld (res_vld),
		.res     (res)
	);

	// output register with skid stage
	logic arrive;
	assign arrive = go && res_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= arrive;
			end
		end else if (arrive) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (arrive) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_vld_q;
	assign position      = out_q.position;
	assign velocity      = out_q.velocity;
	assign acceleration  = out_q.acceleration;
	assign window_status = out_q.status;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a transfer while output is empty");

	a_rest_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_status != qts_pkg::WIN_INSIDE
		|-> velocity == '0 && acceleration == '0)
		else $error("motion outside the move window");

	a_frozen_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !$past(skid_vld_q) |-> !in_ready)
		else $error("input taken while skid is full");

endmodule

`default_nettype wire

// ===== sim/quintic_trajectory_checker.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_checker
// Watches the configuration port and both channels of the trajectory sampler,
// predicts position, velocity, acceleration and window status for every
// accepted time stamp, and compares each result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module quintic_trajectory_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [qts_pkg::DATA_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [qts_pkg::DATA_W-1:0]   sample_time,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic signed [qts_pkg::DATA_W-1:0] position,
	input  wire logic signed [qts_pkg::VEL_W-1:0]  velocity,
	input  wire logic signed [qts_pkg::ACC_W-1:0]  acceleration,
	input  wire logic [1:0]                   window_status,
	output int                                failures,
	output int                                pending
);

	localparam int FB = qts_pkg::TAU_FRAC_BITS;
	localparam logic [63:0] ONE = 64'd1 << FB;

	typedef struct packed {
		logic [31:0] pos;
		logic [47:0] vel;
		logic [63:0] acc;
		qts_pkg::win_status_t win;
	} sample_t;

	logic signed [31:0] move_from, move_to;
	logic [31:0] move_begin, move_len;
	sample_t expected_samples[$];

	assign pending = expected_samples.size();

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return p[FB+63:FB];
	endfunction

	// sign * floor(mag*p*2^k / (2^FB * len^ndiv)), saturated to width bits
	function automatic logic [63:0] scale_rate(input logic [63:0] mag, input logic [63:0] p,
			input logic neg, input int k, input int ndiv, input logic [63:0] len,
			input int width);
		logic [127:0] w;
		logic [63:0] lim, v;
		w = mag * p;
		w = (w << k) >> FB;
		for (int i = 0; i < ndiv; i++)
			w = w / len;
		lim = (64'd1 << (width - 1)) - (neg ? 64'd0 : 64'd1);
		v = (w > {64'd0, lim}) ? lim : w[63:0];
		if (neg)
			v = -v;
		if (width < 64)
			v = v & ((64'd1 << width) - 1);
		return v;
	endfunction

	function automatic sample_t sample_move(input logic [31:0] t);
		sample_t r;
		logic [63:0] len, e, tau, u, tau2, tau3, inner, s, s1, s2, w, dmag, pmag;
		logic [63:0] vel_full;
		logic signed [63:0] d, p;
		logic dneg, wneg;
		len = (move_len == 0) ? 64'd1 : {32'd0, move_len};
		r.win = qts_pkg::WIN_INSIDE;
		if (t < move_begin) begin
			tau = 0;
			r.win = qts_pkg::WIN_BEFORE;
		end else begin
			e = {32'd0, t - move_begin};
			if (e > len) begin
				tau = ONE;
				r.win = qts_pkg::WIN_AFTER;
			end else if (e == len) begin
				tau = ONE;
			end else begin
				tau = (e << FB) / len;
			end
		end
		u = ONE - tau;
		tau2 = qmul(tau, tau);
		tau3 = qmul(tau2, tau);
		inner = 10 * ONE - 15 * tau + 6 * tau2;
		s = qmul(tau3, inner);
		s1 = 30 * qmul(tau2, qmul(u, u));
		wneg = (2 * tau) > ONE;
		w = wneg ? 2 * tau - ONE : ONE - 2 * tau;
		s2 = 60 * qmul(qmul(tau, u), w);
		d = 64'(move_to) - 64'(move_from);
		dneg = d < 0;
		dmag = dneg ? -d : d;
		pmag = qmul(dmag, s);
		p = 64'(move_from) + (dneg ? -$signed(pmag) : $signed(pmag));
		r.pos = p[31:0];
		vel_full = scale_rate(dmag, s1, dneg, qts_pkg::VEL_SHIFT, 1, len, qts_pkg::VEL_W);
		r.vel = vel_full[qts_pkg::VEL_W-1:0];
		r.acc = scale_rate(dmag, s2, dneg != wneg, qts_pkg::ACC_SHIFT, 2, len,
			qts_pkg::ACC_W);
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		failures++;
	endtask

	initial failures = 0;

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		if (!arst_n) begin
			move_from <= 0;
			move_to <= 0;
			move_begin <= 0;
			move_len <= 1;
			expected_samples.delete();
		end else begin
			if (cfg_wr_en) begin
				case (qts_pkg::cfg_reg_t'(cfg_index))
					qts_pkg::REG_START_POS:  move_from <= cfg_wdata;
					qts_pkg::REG_GOAL_POS:   move_to <= cfg_wdata;
					qts_pkg::REG_START_TIME: move_begin <= cfg_wdata;
					qts_pkg::REG_DURATION:   move_len <= cfg_wdata;
				endcase
			end
			if (in_valid && in_ready)
				expected_samples.push_back(sample_move(sample_time));
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report("unexpected transfer", 0, 0);
				end else begin
					want = expected_samples.pop_front();
					if (position !== want.pos)
						report("position", 64'(position), 64'(want.pos));
					if (velocity !== want.vel)
						report("velocity", 64'(velocity), 64'(want.vel));
					if (acceleration !== want.acc)
						report("acceleration", acceleration, want.acc);
					if (window_status !== want.win)
						report("window_status", 64'(window_status), 64'(want.win));
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives time stamps through the quintic trajectory sampler under a series of
// move settings (directed extremes, then random moves) with random gaps and
// output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n, cfg_wr_en, in_valid, out_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_wdata, sample_time;
	logic in_ready, out_valid;
	logic signed [31:0] position;
	logic signed [47:0] velocity;
	logic signed [63:0] acceleration;
	logic [1:0] window_status;
	int failures, pending, quiet_cycles;
	logic calm;

	quintic_trajectory_sampler i_dut (.*);
	quintic_trajectory_checker i_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(negedge clk)
		out_ready <= calm || ($urandom_range(99) >= 10);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// call at a falling edge, once the block is idle
	task automatic set_move(input logic [31:0] from, input logic [31:0] to,
			input logic [31:0] at, input logic [31:0] len);
		logic [31:0] vals[4];
		vals = '{from, to, at, len};
		foreach (vals[i]) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'(i);
			cfg_wdata <= vals[i];
			@(negedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send(input logic [31:0] t);
		if (!calm)
			while ($urandom_range(99) < 10) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		in_valid <= 1'b1;
		sample_time <= t;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	initial begin
		logic [31:0] from, to, at, len, off;
		logic [31:0] probe[8];
		int pick;
		quiet_cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = qts_pkg::REG_START_POS;
		cfg_wdata = 0;
		in_valid = 1'b0;
		sample_time = 0;
		out_ready = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings, then widest moves in both directions
		send(32'd0);
		send(32'd1);
		drain();
		set_move(32'h8000_0000, 32'h7fff_ffff, 32'd100, 32'd1000);
		probe = '{32'd0, 32'd99, 32'd100, 32'd350, 32'd600, 32'd1100, 32'd1101,
			32'hffff_ffff};
		foreach (probe[i])
			send(probe[i]);
		drain();
		// zero duration acts as one tick
		set_move(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'd0);
		send(32'hffff_fffe);
		send(32'hffff_ffff);
		send(32'd0);
		drain();
		set_move(32'd0, 32'h0001_0000, 32'd0, 32'hffff_ffff);
		send(32'd0);
		send(32'h7fff_ffff);
		send(32'hffff_ffff);
		drain();
		// short move with full swing: rates saturate
		set_move(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd3);
		send(32'd1);
		send(32'd2);
		drain();
		set_move(32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd2);
		send(32'd1);
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			calm = (phase == 5);
			from = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(
				0, 2000000)) - 1000000);
			to = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(
				0, 2000000)) - 1000000);
			at = $urandom();
			pick = $urandom_range(9);
			len = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom() :
				(pick == 2) ? 32'hffff_ffff : $urandom_range(1, 5000);
			set_move(from, to, at, len);
			for (int n = 0; n < 95; n++) begin
				pick = $urandom_range(9);
				if (pick < 8) begin
					off = (len > 32'h4000_0000) ? $urandom() % len :
						$urandom_range(0, len + len / 4 + 1);
					send(at + off);
				end else if (pick == 8) begin
					send(at - $urandom_range(1, 1000));
				end else begin
					send($urandom());
				end
			end
			drain();
		end
		calm = 1'b0;

		repeat (150) @(negedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
